>>> src/vmclp_pkg.sv
// ----------------------------------------------------------------------------
// vmclp_pkg: shared types and word tables of the VM command line parser
// Status codes, command kinds, parse positions and the packed command and
// segment words used to match tokens.
// ----------------------------------------------------------------------------
package vmclp_pkg;

  localparam int INDEX_BITS = 15;
  localparam int IndexOutW  = 15;
  localparam int TokenW     = 64;
  localparam int TokenLenW  = 4;
  localparam int NumCmd     = 11;
  localparam int NumSeg     = 8;
  localparam int OutW       = 32;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SKIP    = 3'd1,
    ST_BAD_CMD = 3'd2,
    ST_BAD_SEG = 3'd3,
    ST_BAD_IDX = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_ARITH = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_POP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FP_CMD  = 2'd0,
    FP_SEG  = 2'd1,
    FP_IDX  = 2'd2,
    FP_DONE = 2'd3
  } field_pos_t;

  localparam logic [3:0] CMD_PUSH = 4'd9;
  localparam logic [3:0] CMD_POP  = 4'd10;
  localparam logic [3:0] CMD_NONE = 4'd11;
  localparam logic [3:0] SEG_NONE = 4'd8;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // add sub neg eq gt lt and or not push pop, first char in the low byte
  localparam logic [TokenW-1:0] CMD_CHARS [NumCmd] = '{
    64'h646461, 64'h627573, 64'h67656e, 64'h7165, 64'h7467, 64'h746c,
    64'h646e61, 64'h726f, 64'h746f6e, 64'h68737570, 64'h706f70
  };
  localparam logic [TokenLenW-1:0] CMD_LEN [NumCmd] = '{
    4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd3
  };

  // local constant argument pointer this that static temp
  localparam logic [TokenW-1:0] SEG_CHARS [NumSeg] = '{
    64'h6c61636f6c, 64'h746e6174736e6f63, 64'h746e656d75677261,
    64'h7265746e696f70, 64'h73696874, 64'h74616874, 64'h636974617473,
    64'h706d6574
  };
  localparam logic [TokenLenW-1:0] SEG_LEN [NumSeg] = '{
    4'd5, 4'd8, 4'd8, 4'd7, 4'd4, 4'd4, 4'd6, 4'd4
  };

endpackage

>>> src/vm_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// vm_command_line_parser_core: VM command line parser
// Parses one text line per frame of byte beats into one result beat.
//
// Channel   Dir  Beat                      Notes
// s_axis    in   one character             tlast on final byte of the line
// m_axis    out  one parsed command        one beat per line
//
// Input beats are taken back to back; the line result is registered: its last
// byte passes the input register, then the result goes into the result register.
// Reset is synchronous and returns the parser to the start of a line.
// A stalled result only blocks the input when another line end reaches it.
// ----------------------------------------------------------------------------
module vm_command_line_parser_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] char_byte
  input  logic                        s_axis_tlast,  // line_end
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [2:0] status, [4:3] command_kind, [8:5] arithmetic_op, [11:9] segment,
  // [26:12] index_value, [27] index_saturated, [31:28] zero
  output logic [vmclp_pkg::OutW-1:0]  m_axis_tdata
);
  import vmclp_pkg::*;

  typedef struct packed {
    field_pos_t            pos;
    logic [1:0]            chars_seen;
    logic                  comment;
    logic                  all_space;
    logic                  ended;
    logic [TokenW-1:0]     tok;
    logic [TokenLenW-1:0]  tok_len;
    kind_t                 kind;
    logic [3:0]            op;
    logic [2:0]            seg;
    logic [INDEX_BITS-1:0] idx;
    logic                  sat;
    status_t               err;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    pos: FP_CMD, chars_seen: 2'd0, comment: 1'b0, all_space: 1'b1,
    ended: 1'b0, tok: '0, tok_len: '0, kind: KIND_ARITH, op: 4'd0,
    seg: 3'd0, idx: '0, sat: 1'b0, err: ST_OK
  };

  localparam logic [INDEX_BITS+3:0] IdxLimit = (INDEX_BITS+4)'((1 << INDEX_BITS) - 1);

  function automatic logic [3:0] match_cmd(input logic [TokenW-1:0] t,
                                            input logic [TokenLenW-1:0] n);
    logic [3:0] r;
    r = CMD_NONE;
    for (int i = NumCmd - 1; i >= 0; i--) begin
      if (t == CMD_CHARS[i] && n == CMD_LEN[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] match_seg(input logic [TokenW-1:0] t,
                                            input logic [TokenLenW-1:0] n);
    logic [3:0] r;
    r = SEG_NONE;
    for (int i = NumSeg - 1; i >= 0; i--) begin
      if (t == SEG_CHARS[i] && n == SEG_LEN[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic parse_state_t set_error(input parse_state_t s, input status_t code);
    parse_state_t r;
    r = s;
    if (r.err == ST_OK) r.err = code;
    r.pos = FP_DONE;
    return r;
  endfunction

  function automatic parse_state_t finish_field(input parse_state_t s);
    parse_state_t r;
    logic [3:0]   c;
    logic [3:0]   g;
    r = s;
    c = match_cmd(s.tok, s.tok_len);
    g = match_seg(s.tok, s.tok_len);
    case (s.pos)
      FP_CMD: begin
        if (c == CMD_NONE) begin
          r = set_error(r, ST_BAD_CMD);
        end else if (c == CMD_PUSH) begin
          r.kind = KIND_PUSH;
          r.pos  = FP_SEG;
        end else if (c == CMD_POP) begin
          r.kind = KIND_POP;
          r.pos  = FP_SEG;
        end else begin
          r.kind = KIND_ARITH;
          r.op   = c;
          r.pos  = FP_DONE;
        end
      end
      FP_SEG: begin
        if (g == SEG_NONE) begin
          r = set_error(r, ST_BAD_SEG);
        end else begin
          r.seg = g[2:0];
          r.pos = FP_IDX;
        end
      end
      FP_IDX: begin
        if (s.tok_len == '0) r = set_error(r, ST_BAD_IDX);
        else r.pos = FP_DONE;
      end
      default: ;
    endcase
    r.tok     = '0;
    r.tok_len = '0;
    return r;
  endfunction

  function automatic parse_state_t end_content(input parse_state_t s);
    parse_state_t r;
    r = finish_field(s);
    if (r.pos == FP_SEG) r = set_error(r, ST_BAD_SEG);
    else if (r.pos == FP_IDX) r = set_error(r, ST_BAD_IDX);
    r.pos   = FP_DONE;
    r.ended = 1'b1;
    return r;
  endfunction

  function automatic parse_state_t take_char(input parse_state_t s, input logic [7:0] ch);
    parse_state_t          r;
    logic [INDEX_BITS+3:0] acc;
    r = s;
    if (ch == CH_NUL || ch == CH_LF) return end_content(r);
    if (r.chars_seen == 2'd0) r.comment = (ch == CH_SLASH);
    else if (r.chars_seen == 2'd1) r.comment = r.comment && (ch == CH_SLASH);
    if (r.chars_seen != 2'd2) r.chars_seen = r.chars_seen + 2'd1;
    if (ch == CH_SPACE) return finish_field(r);
    r.all_space = 1'b0;
    if (r.pos == FP_IDX) begin
      if (ch < CH_ZERO || ch > CH_NINE) begin
        r = set_error(r, ST_BAD_IDX);
      end else begin
        acc = ((INDEX_BITS+4)'(r.idx) << 3) + ((INDEX_BITS+4)'(r.idx) << 1)
              + (INDEX_BITS+4)'(ch - CH_ZERO);
        if (acc > IdxLimit) begin
          r.idx = IdxLimit[INDEX_BITS-1:0];
          r.sat = 1'b1;
        end else begin
          r.idx = acc[INDEX_BITS-1:0];
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (!r.tok_len[3] && r.tok_len[2:0] == 3'(i)) r.tok[8*i +: 8] = ch;
    end
    if (r.tok_len != 4'hf) r.tok_len = r.tok_len + 4'd1;
    return r;
  endfunction

  logic               in_valid;
  logic [7:0]         in_char;
  logic               in_last;
  logic               advance;
  parse_state_t       st;
  parse_state_t       st_take;
  parse_state_t       st_next;
  status_t            res_status;
  logic [OutW-1:0]    res_data;

  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_comb begin
    st_take = st.ended ? st : take_char(st, in_char);
    st_next = (in_last && !st_take.ended) ? end_content(st_take) : st_take;
    if (st_next.comment && st_next.chars_seen == 2'd2) res_status = ST_SKIP;
    else if (st_next.all_space) res_status = ST_SKIP;
    else res_status = st_next.err;
    res_data = '0;
    res_data[2:0] = res_status;
    if (res_status == ST_OK) begin
      res_data[4:3] = st_next.kind;
      if (st_next.kind == KIND_ARITH) begin
        res_data[8:5] = st_next.op;
      end else begin
        res_data[11:9]  = st_next.seg;
        res_data[26:12] = IndexOutW'(st_next.idx);
        res_data[27]    = st_next.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= PARSE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        st <= in_last ? PARSE_RESET : st_next;
      end
      if (advance && in_last) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (advance && in_last) begin
      m_axis_tdata <= res_data;
    end
  end

endmodule

>>> src/vmclp_checker.sv
// ----------------------------------------------------------------------------
// vmclp_checker: port checks of the VM command line parser
// Watches the result beats for held data and consistent field coding.
// ----------------------------------------------------------------------------
module vmclp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [7:0]                 s_axis_tdata,
  input logic                       s_axis_tlast,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [vmclp_pkg::OutW-1:0] m_axis_tdata
);
  import vmclp_pkg::*;

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ s_axis_tlast ^ (^s_axis_tdata);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_no_beat_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_BAD_IDX)
    else $error("status code out of range");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[31:3] == '0)
    else $error("fields set on a skipped or failed line");

  a_arith_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == ST_OK && m_axis_tdata[4:3] == KIND_ARITH
    |-> m_axis_tdata[31:9] == '0)
    else $error("segment or index set on an arithmetic command");

endmodule

bind vm_command_line_parser_core vmclp_checker u_vmclp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
